// ----- rtl/lidar_beam_to_world_points_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Lidar beam projection: assertion macros
// Concurrent assertion forms for the projection unit's sequencer.
// ----------------------------------------------------------------------------
`ifndef LIDAR_BEAM_TO_WORLD_POINTS_UNIT_ASSERT_SVH
`define LIDAR_BEAM_TO_WORLD_POINTS_UNIT_ASSERT_SVH

// checked only out of reset
`define LBWP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define LBWP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/lbwp_pkg.sv -----
// ----------------------------------------------------------------------------
// lbwp_pkg
// Types, constants and the arctangent table of the beam projection unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lbwp_pkg;

  localparam int BEAM_COUNT       = 360;
  localparam int BEAM_WIN         = 90;
  localparam int CORDIC_STEPS_DEF = 18;
  localparam int STEP_W           = 5;
  localparam int XW               = 38;
  localparam int ZW               = 23;

  localparam logic signed [ZW-1:0] PI_Q16      = 23'sd205887;
  localparam logic signed [ZW-1:0] HALF_PI_Q16 = 23'sd102944;
  localparam logic signed [ZW-1:0] DEG_Q16     = 23'sd1144;
  localparam logic signed [XW-1:0] GAIN_Q30    = 38'sd652032875;
  localparam logic signed [33:0]   ONE_Q28     = 34'sd268435456;

  localparam logic [23:0] MAX_RANGE_RST     = 24'd131072;
  localparam logic [19:0] SENSOR_OFFSET_RST = 20'd21621;

  typedef enum logic {
    CFG_MAX_RANGE     = 1'b0,
    CFG_SENSOR_OFFSET = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    REQ_POSE = 1'b0,
    REQ_BEAM = 1'b1
  } req_t;

  typedef struct packed {
    logic               req_type;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic [8:0]         beam_index;
    logic [23:0]        beam_range;
    logic               range_is_inf;
    logic               beam_last;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic               point_valid;
    logic               last_of_scan;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DEC,
    ST_VSTEP,
    ST_RPREP,
    ST_RSTEP,
    ST_HEAD,
    ST_MOUNT,
    ST_BMUL,
    ST_BOUT
  } state_t;

  typedef struct packed {
    logic              load;
    logic              vprep;
    logic              bchk;
    logic              vstep;
    logic              rprep;
    logic              rstep;
    logic              head;
    logic              mount;
    logic              bmul;
    logic              bout;
    logic [STEP_W-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic is_beam;
    logic beam_go;
    logic beam_last;
    logic out_free;
  } status_t;

  function automatic logic [15:0] atan_q16(input logic [STEP_W-1:0] i);
    logic [15:0] r;
    case (i)
      5'd0:    r = 16'd51472;
      5'd1:    r = 16'd30385;
      5'd2:    r = 16'd16055;
      5'd3:    r = 16'd8150;
      5'd4:    r = 16'd4091;
      5'd5:    r = 16'd2047;
      5'd6:    r = 16'd1024;
      5'd7:    r = 16'd512;
      5'd8:    r = 16'd256;
      5'd9:    r = 16'd128;
      5'd10:   r = 16'd64;
      5'd11:   r = 16'd32;
      5'd12:   r = 16'd16;
      5'd13:   r = 16'd8;
      5'd14:   r = 16'd4;
      5'd15:   r = 16'd2;
      5'd16:   r = 16'd1;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/lbwp_ctrl.sv -----
// ----------------------------------------------------------------------------
// lbwp_ctrl
// Sequencer: decode, CORDIC step counting and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lidar_beam_to_world_points_unit_assert.svh"

module lbwp_ctrl #(
  parameter int CORDIC_STEPS = lbwp_pkg::CORDIC_STEPS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  lbwp_pkg::status_t sts,
  output lbwp_pkg::cmd_t   cmd
);

  localparam int SW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [SW-1:0] LAST_STEP = SW'(CORDIC_STEPS - 1);

  lbwp_pkg::state_t state, state_next;
  logic [SW-1:0]    step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lbwp_pkg::ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    unique case (state)
      lbwp_pkg::ST_IDLE: begin
        if (in_valid) state_next = lbwp_pkg::ST_DEC;
      end
      lbwp_pkg::ST_DEC: begin
        if (!sts.is_beam) state_next = lbwp_pkg::ST_VSTEP;
        else if (sts.beam_go) state_next = lbwp_pkg::ST_RPREP;
        else if (sts.beam_last) state_next = lbwp_pkg::ST_BOUT;
        else state_next = lbwp_pkg::ST_IDLE;
      end
      lbwp_pkg::ST_VSTEP: begin
        if (step == LAST_STEP) begin
          step_next  = '0;
          state_next = lbwp_pkg::ST_RPREP;
        end else begin
          step_next = step + 1'b1;
        end
      end
      lbwp_pkg::ST_RPREP: state_next = lbwp_pkg::ST_RSTEP;
      lbwp_pkg::ST_RSTEP: begin
        if (step == LAST_STEP) begin
          step_next  = '0;
          state_next = sts.is_beam ? lbwp_pkg::ST_BMUL : lbwp_pkg::ST_HEAD;
        end else begin
          step_next = step + 1'b1;
        end
      end
      lbwp_pkg::ST_HEAD:  state_next = lbwp_pkg::ST_MOUNT;
      lbwp_pkg::ST_MOUNT: state_next = lbwp_pkg::ST_IDLE;
      lbwp_pkg::ST_BMUL:  state_next = lbwp_pkg::ST_BOUT;
      lbwp_pkg::ST_BOUT: begin
        if (sts.out_free) state_next = lbwp_pkg::ST_IDLE;
      end
      default: state_next = lbwp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.step = lbwp_pkg::STEP_W'(step);
    in_stall = 1'b1;
    unique case (state)
      lbwp_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      lbwp_pkg::ST_DEC: begin
        cmd.vprep = !sts.is_beam;
        cmd.bchk  = sts.is_beam;
      end
      lbwp_pkg::ST_VSTEP: cmd.vstep = 1'b1;
      lbwp_pkg::ST_RPREP: cmd.rprep = 1'b1;
      lbwp_pkg::ST_RSTEP: cmd.rstep = 1'b1;
      lbwp_pkg::ST_HEAD:  cmd.head  = 1'b1;
      lbwp_pkg::ST_MOUNT: cmd.mount = 1'b1;
      lbwp_pkg::ST_BMUL:  cmd.bmul  = 1'b1;
      lbwp_pkg::ST_BOUT:  cmd.bout  = sts.out_free;
      default: ;
    endcase
  end

  `LBWP_ASSERT(a_step_range, (step <= LAST_STEP), "step counter past last step")
  `LBWP_ASSERT(a_accept_dec, (in_valid && !in_stall) |=> (state == lbwp_pkg::ST_DEC), "accept did not decode")
  `LBWP_ASSERT(a_vec_to_rot, (state == lbwp_pkg::ST_VSTEP && step == LAST_STEP) |=> (state == lbwp_pkg::ST_RPREP), "vectoring did not hand over")
  `LBWP_ASSERT_ALWAYS(a_step_idle, (state == lbwp_pkg::ST_IDLE) |-> (step == '0), "step counter not cleared")

endmodule

// ----- rtl/lbwp_datapath.sv -----
// ----------------------------------------------------------------------------
// lbwp_datapath
// Pose state, shared iterative CORDIC, multipliers and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lbwp_datapath (
  input  logic                clk,
  input  logic                rst,
  input  lbwp_pkg::in_item_t  in_data,
  input  lbwp_pkg::cmd_t      cmd,
  output lbwp_pkg::status_t   sts,
  input  logic                cfg_valid,
  input  logic                cfg_index,
  input  logic [23:0]         cfg_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lbwp_pkg::out_item_t out_data
);

  localparam int XW = lbwp_pkg::XW;
  localparam int ZW = lbwp_pkg::ZW;

  lbwp_pkg::in_item_t  item;
  logic [23:0]         max_range;
  logic [19:0]         sensor_offset;
  logic signed [17:0]  heading_cos, heading_sin;
  logic signed [19:0]  heading_angle;
  logic signed [31:0]  mount_x, mount_y;
  logic signed [XW-1:0] x, y;
  logic signed [ZW-1:0] z;
  logic                vzero, neg;
  logic signed [56:0]  prx, pry;

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      max_range     <= lbwp_pkg::MAX_RANGE_RST;
      sensor_offset <= lbwp_pkg::SENSOR_OFFSET_RST;
    end else if (cfg_valid) begin
      unique case (lbwp_pkg::cfg_idx_t'(cfg_index))
        lbwp_pkg::CFG_MAX_RANGE:     max_range     <= cfg_data;
        lbwp_pkg::CFG_SENSOR_OFFSET: sensor_offset <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  // beam decode
  logic               win_hi, win_lo, active;
  logic signed [10:0] deg;
  always_comb begin
    win_hi = (item.beam_index >= 9'(lbwp_pkg::BEAM_COUNT - lbwp_pkg::BEAM_WIN)) &&
             (item.beam_index < 9'(lbwp_pkg::BEAM_COUNT));
    win_lo = item.beam_index < 9'(lbwp_pkg::BEAM_WIN);
    active = win_hi || win_lo;
    if (win_hi) deg = $signed({2'b00, item.beam_index}) - 11'sd360;
    else if (win_lo) deg = $signed({2'b00, item.beam_index}) + 11'sd1;
    else deg = '0;
  end

  logic beam_go_c;
  assign beam_go_c = active && !item.range_is_inf && (item.beam_range < max_range);

  assign sts.is_beam   = (item.req_type == lbwp_pkg::REQ_BEAM);
  assign sts.beam_go   = beam_go_c;
  assign sts.beam_last = item.beam_last;
  assign sts.out_free  = !out_valid || !out_stall;

  // quaternion terms
  logic signed [31:0] p_wz, p_xy, p_yy, p_zz;
  logic signed [33:0] t1, t2;
  logic signed [XW-1:0] t1x, t2x;
  always_comb begin
    p_wz = item.quat_w * item.quat_z;
    p_xy = item.quat_x * item.quat_y;
    p_yy = item.quat_y * item.quat_y;
    p_zz = item.quat_z * item.quat_z;
    t1   = (34'(p_wz) + 34'(p_xy)) <<< 1;
    t2   = lbwp_pkg::ONE_Q28 - ((34'(p_yy) + 34'(p_zz)) <<< 1);
    t1x  = XW'(t1);
    t2x  = XW'(t2);
  end

  // CORDIC step terms
  logic signed [XW-1:0] dx, dy;
  logic signed [ZW-1:0] tab;
  assign dx  = x >>> cmd.step;
  assign dy  = y >>> cmd.step;
  assign tab = $signed({7'd0, lbwp_pkg::atan_q16(cmd.step)});

  logic signed [ZW-1:0] ang, bang;
  assign ang  = (!sts.is_beam && vzero) ? '0 : z;
  assign bang = ZW'(heading_angle) + ZW'(ZW'(deg) * lbwp_pkg::DEG_Q16);

  logic signed [XW-1:0] cx, cy, rcx, rcy;
  assign cx  = neg ? -x : x;
  assign cy  = neg ? -y : y;
  assign rcx = (cx + XW'(38'sd8192)) >>> 14;
  assign rcy = (cy + XW'(38'sd8192)) >>> 14;

  logic signed [38:0] mpx, mpy, mrx, mry;
  assign mpx = $signed({1'b0, sensor_offset}) * heading_cos;
  assign mpy = $signed({1'b0, sensor_offset}) * heading_sin;
  assign mrx = (mpx + 39'sd32768) >>> 16;
  assign mry = (mpy + 39'sd32768) >>> 16;

  logic signed [56:0] orx, ory;
  assign orx = (prx + 57'sd536870912) >>> 30;
  assign ory = (pry + 57'sd536870912) >>> 30;

  always_ff @(posedge clk) begin
    if (cmd.load) item <= in_data;
    if (cmd.vprep) begin
      vzero <= (t1 == '0) && (t2 == '0);
      if (t2 < 0) begin
        x <= -t2x;
        y <= -t1x;
        z <= (t1 >= 0) ? lbwp_pkg::PI_Q16 : -lbwp_pkg::PI_Q16;
      end else begin
        x <= t2x;
        y <= t1x;
        z <= '0;
      end
    end
    if (cmd.bchk) z <= bang;
    if (cmd.vstep) begin
      if (!y[XW-1]) begin
        x <= x + dy; y <= y - dx; z <= z + tab;
      end else begin
        x <= x - dy; y <= y + dx; z <= z - tab;
      end
    end
    if (cmd.rprep) begin
      x <= lbwp_pkg::GAIN_Q30;
      y <= '0;
      if (ang > lbwp_pkg::HALF_PI_Q16) begin
        z <= ang - lbwp_pkg::PI_Q16; neg <= 1'b1;
      end else if (ang < -lbwp_pkg::HALF_PI_Q16) begin
        z <= ang + lbwp_pkg::PI_Q16; neg <= 1'b1;
      end else begin
        z <= ang; neg <= 1'b0;
      end
    end
    if (cmd.rstep) begin
      if (!z[ZW-1]) begin
        x <= x - dy; y <= y + dx; z <= z - tab;
      end else begin
        x <= x + dy; y <= y - dx; z <= z + tab;
      end
    end
    if (cmd.bmul) begin
      prx <= $signed({1'b0, item.beam_range}) * $signed(cx[31:0]);
      pry <= $signed({1'b0, item.beam_range}) * $signed(cy[31:0]);
    end
  end

  // pose state
  always_ff @(posedge clk) begin
    if (rst) begin
      heading_cos   <= '0;
      heading_sin   <= '0;
      heading_angle <= '0;
      mount_x       <= '0;
      mount_y       <= '0;
    end else begin
      if (cmd.rprep && !sts.is_beam) heading_angle <= ang[19:0];
      if (cmd.head) begin
        heading_cos <= rcx[17:0];
        heading_sin <= rcy[17:0];
      end
      if (cmd.mount) begin
        mount_x <= item.pos_x + mrx[31:0];
        mount_y <= item.pos_y + mry[31:0];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.bout) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.bout) begin
      out_data.point_x      <= beam_go_c ? mount_x + orx[31:0] : '0;
      out_data.point_y      <= beam_go_c ? mount_y + ory[31:0] : '0;
      out_data.point_valid  <= beam_go_c;
      out_data.last_of_scan <= item.beam_last;
    end
  end

endmodule

// ----- rtl/lidar_beam_to_world_points_unit.sv -----
// ----------------------------------------------------------------------------
// lidar_beam_to_world_points_unit
// Turns pose and lidar beam items into world-frame obstacle points.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall, in_data): one pose or beam item per beat.
// Output channel (out_valid/out_stall, out_data): at most one point per beam.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready;
//   index 0 max_range, index 1 sensor_offset; write only while idle.
// One item is processed at a time by a single iterative CORDIC unit that
// does one micro-rotation per cycle:
//   pose item : atan2 vectoring then sine/cosine rotation, then heading and
//               mount position registers; no result, next item after that.
//   beam item : rotation, range multiply, then the result register; the next
//               item is accepted once the result register is free;
//               a rejected beam skips the CORDIC; if last, it gives an empty point.
// The result register lets the next item be accepted while a beat waits.
// A stalled receiver holds the result; a second result waits for it.
// Reset (rst, synchronous) clears the pose state, empties the result
// register and loads the default range limit and mount offset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lidar_beam_to_world_points_unit #(
  parameter int CORDIC_STEPS = lbwp_pkg::CORDIC_STEPS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  lbwp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lbwp_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [23:0]         cfg_data
);

  lbwp_pkg::cmd_t    cmd;
  lbwp_pkg::status_t sts;

  assign cfg_ready = 1'b1;

  lbwp_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lbwp_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- bench/tb_lidar_beam_to_world_points_unit.sv -----
// ----------------------------------------------------------------------------
// Lidar beam projection unit testbench
// Drives pose and beam items with random gaps, predicts each world point
// with a bit-exact CORDIC model and checks results in order. Runs several
// range limit and mount offset settings, extremes included.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_lidar_beam_to_world_points_unit;

  localparam int STEPS    = 18;
  localparam int WD_LIMIT = 20000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  lbwp_pkg::in_item_t    in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  lbwp_pkg::out_item_t   out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic                  cfg_index = 1'b0;
  logic [23:0]           cfg_data = '0;

  lidar_beam_to_world_points_unit #(.CORDIC_STEPS(STEPS)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  lbwp_pkg::in_item_t  pending_items[$];
  lbwp_pkg::out_item_t expected_points[$];

  logic [23:0]        lim_range = lbwp_pkg::MAX_RANGE_RST;
  logic [19:0]        mount_off = lbwp_pkg::SENSOR_OFFSET_RST;
  longint             hd_cos, hd_sin, hd_ang;
  logic [31:0]        mnt_x = '0, mnt_y = '0;

  int  errors = 0;
  int  in_gap = 0, out_gap = 0;
  int  hold_off = 0;
  int  idle_cycles = 0;
  bit  done = 0;

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint atan_step(int i);
    return (i < 17) ? longint'(lbwp_pkg::atan_q16(i[lbwp_pkg::STEP_W-1:0])) : 0;
  endfunction

  task automatic add_item(input lbwp_pkg::in_item_t it);
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic add_point(input lbwp_pkg::out_item_t r);
    expected_points.insert(expected_points.size(), r);
  endtask

  function automatic longint yaw_of(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? 205887 : -205887;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = asr(x, i);
      dy = asr(y, i);
      if (y >= 0) begin
        x += dy; y -= dx; z += atan_step(i);
      end else begin
        x -= dy; y += dx; z -= atan_step(i);
      end
    end
    return longint'(int'(z));
  endfunction

  task automatic rotate(input longint ang, output longint c, output longint s);
    longint x, y, z, dx, dy;
    bit neg;
    x = 652032875; y = 0; z = ang; neg = 0;
    if (z > 102944) begin
      z -= 205887; neg = 1;
    end else if (z < -102944) begin
      z += 205887; neg = 1;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = asr(x, i);
      dy = asr(y, i);
      if (z >= 0) begin
        x -= dy; y += dx; z -= atan_step(i);
      end else begin
        x += dy; y -= dx; z += atan_step(i);
      end
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
  endtask

  task automatic project(input lbwp_pkg::in_item_t it);
    longint t1, t2, c, s, deg;
    bit active;
    lbwp_pkg::out_item_t r;
    if (it.req_type == lbwp_pkg::REQ_POSE) begin
      t1 = 2 * (longint'(it.quat_w) * it.quat_z + longint'(it.quat_x) * it.quat_y);
      t2 = 268435456 - 2 * (longint'(it.quat_y) * it.quat_y
                            + longint'(it.quat_z) * it.quat_z);
      hd_ang = yaw_of(t1, t2);
      rotate(hd_ang, c, s);
      hd_cos = round_shift(c, 14);
      hd_sin = round_shift(s, 14);
      mnt_x = it.pos_x + 32'(round_shift(longint'(mount_off) * hd_cos, 16));
      mnt_y = it.pos_y + 32'(round_shift(longint'(mount_off) * hd_sin, 16));
    end else begin
      active = 1;
      deg = 0;
      if (it.beam_index >= 270 && it.beam_index < 360) deg = longint'(it.beam_index) - 360;
      else if (it.beam_index < 90) deg = longint'(it.beam_index) + 1;
      else active = 0;
      if (active && !it.range_is_inf && it.beam_range < lim_range) begin
        rotate(hd_ang + deg * 1144, c, s);
        r.point_x = mnt_x + 32'(round_shift(longint'(it.beam_range) * c, 30));
        r.point_y = mnt_y + 32'(round_shift(longint'(it.beam_range) * s, 30));
        r.point_valid = 1'b1;
        r.last_of_scan = it.beam_last;
        add_point(r);
      end else if (it.beam_last) begin
        r = '0;
        r.last_of_scan = 1'b1;
        add_point(r);
      end
    end
  endtask

  function automatic logic signed [15:0] quat_term();
    case ($urandom_range(0, 9))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'($urandom);
      3: return 16'sd0;
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic lbwp_pkg::in_item_t pose_item(int span);
    lbwp_pkg::in_item_t it;
    it = '0;
    it.req_type = lbwp_pkg::REQ_POSE;
    it.pos_x = (span == 0) ? 32'($urandom) : 32'($urandom_range(0, 2*span) - span);
    it.pos_y = (span == 0) ? 32'($urandom) : 32'($urandom_range(0, 2*span) - span);
    it.quat_w = quat_term();
    it.quat_x = quat_term();
    it.quat_y = quat_term();
    it.quat_z = quat_term();
    it.beam_index = 9'($urandom);
    it.beam_range = 24'($urandom);
    it.range_is_inf = 1'($urandom);
    it.beam_last = 1'($urandom);
    return it;
  endfunction

  function automatic lbwp_pkg::in_item_t beam_item(int idx, int rng, bit inf, bit last);
    lbwp_pkg::in_item_t it;
    it = '0;
    it.req_type = lbwp_pkg::REQ_BEAM;
    it.pos_x = 32'($urandom);
    it.pos_y = 32'($urandom);
    it.quat_w = 16'($urandom);
    it.quat_z = 16'($urandom);
    it.beam_index = 9'(idx);
    it.beam_range = 24'(rng);
    it.range_is_inf = inf;
    it.beam_last = last;
    return it;
  endfunction

  // scan: pose then beams over both windows, some noise
  task automatic queue_scan(int n);
    int idx;
    add_item(pose_item($urandom_range(0, 1) ? 0 : 1 << 20));
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: idx = $urandom_range(0, 511);
        1, 2, 3, 4: idx = $urandom_range(270, 359);
        default: idx = $urandom_range(0, 89);
      endcase
      add_item(beam_item(idx,
        $urandom_range(0, 5) == 0 ? $urandom_range(0, 24'hFFFFFF)
                                  : $urandom_range(0, 2 * lim_range + 1),
        $urandom_range(0, 7) == 0, i == n - 1 || $urandom_range(0, 19) == 0));
    end
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || expected_points.size() != 0 || in_valid)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(lbwp_pkg::cfg_idx_t idx, logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == lbwp_pkg::CFG_MAX_RANGE) lim_range = val;
    else mount_off = val[19:0];
    @(posedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        project(in_data);
        in_gap = $urandom_range(0, 4);
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0 || pending_items.size() == 0) begin
          in_valid <= 1'b0;
          if (in_gap > 0) in_gap--;
        end else begin
          in_valid <= 1'b1;
          in_data  <= pending_items.pop_front();
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_points.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected point %h", out_data);
        end else if (expected_points[0] !== out_data) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp x=%h y=%h v=%b l=%b got x=%h y=%h v=%b l=%b",
              expected_points[0].point_x, expected_points[0].point_y,
              expected_points[0].point_valid, expected_points[0].last_of_scan,
              out_data.point_x, out_data.point_y,
              out_data.point_valid, out_data.last_of_scan);
          void'(expected_points.pop_front());
        end else begin
          void'(expected_points.pop_front());
        end
        out_gap = $urandom_range(0, 4);
      end
      if (hold_off > 0) begin
        out_stall <= 1'b1;
        hold_off--;
      end else if (out_gap > 0) begin
        out_stall <= 1'b1;
        out_gap--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst && !done) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WD_LIMIT) begin
        $display("tb_lidar_beam_to_world_points_unit: FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic [23:0] ranges[5];
    logic [19:0] offs[5];
    ranges = '{24'd131072, 24'hFFFFFF, 24'd0, 24'd1, 24'd4000000};
    offs   = '{20'd21621, 20'hFFFFF, 20'd0, 20'd1, 20'd300000};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // beams before any pose, then directed extremes
    add_item(beam_item(0, 1000, 0, 0));
    add_item(beam_item(359, 0, 0, 1));
    add_item(beam_item(100, 10, 0, 1));
    add_item(beam_item(511, 10, 0, 0));
    add_item(beam_item(89, 10, 1, 1));
    add_item(beam_item(270, 131071, 0, 0));
    add_item(beam_item(90, 131072, 0, 1));
    add_item(beam_item(269, 5, 0, 0));
    begin
      lbwp_pkg::in_item_t p;
      p = pose_item(0);
      p.quat_w = 0; p.quat_x = 0; p.quat_y = 16384; p.quat_z = 16384;
      p.pos_x = 32'h7FFFFFFF; p.pos_y = 32'h80000000;
      add_item(p);
      add_item(beam_item(0, 131071, 0, 1));
      p.quat_w = 0; p.quat_x = 16384; p.quat_y = -16384; p.quat_z = -16384;
      add_item(p);
      add_item(beam_item(300, 65536, 0, 0));
      p.quat_w = 16'h7FFF; p.quat_x = 16'h8000; p.quat_y = 0; p.quat_z = 0;
      add_item(p);
      add_item(beam_item(45, 1, 0, 1));
      p.quat_w = -16384; p.quat_x = 0; p.quat_y = 0; p.quat_z = 16384;
      add_item(p);
      add_item(beam_item(359, 100000, 0, 0));
    end
    wait_drained();

    for (int ph = 0; ph < 5; ph++) begin
      write_reg(lbwp_pkg::CFG_MAX_RANGE, ranges[ph]);
      write_reg(lbwp_pkg::CFG_SENSOR_OFFSET, {4'h0, offs[ph]});
      for (int s = 0; s < 12; s++) queue_scan($urandom_range(5, 25));
      if (ph == 1) begin
        hold_off = 400;
        while (hold_off > 0) @(posedge clk);
      end
      if (ph == 3) begin
        while (pending_items.size() > 60) @(posedge clk);
        while (pending_items.size() != 0 || in_valid) @(posedge clk);
        while (expected_points.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        for (int s = 0; s < 4; s++) queue_scan($urandom_range(5, 25));
      end
      wait_drained();
    end

    done = 1;
    if (errors == 0 && expected_points.size() == 0)
      $display("tb_lidar_beam_to_world_points_unit: PASS");
    else
      $display("tb_lidar_beam_to_world_points_unit: FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/lbwp_pkg.sv
rtl/lbwp_ctrl.sv
rtl/lbwp_datapath.sv
rtl/lidar_beam_to_world_points_unit.sv
bench/tb_lidar_beam_to_world_points_unit.sv
